// ----- hdl/plf_pkg.sv -----
// shared constants and types for the point to line distance block
package plf_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} plf_qstat_t;

endpackage

// ----- hdl/plf_if.sv -----
// channel interfaces: query items in, distance results out
interface plf_in_if #(parameter int W = 32) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] start_x;
	logic signed [W-1:0] start_y;
	logic signed [W-1:0] start_z;
	logic signed [W-1:0] dir_x;
	logic signed [W-1:0] dir_y;
	logic signed [W-1:0] dir_z;
	logic signed [W-1:0] query_x;
	logic signed [W-1:0] query_y;
	logic signed [W-1:0] query_z;

	modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
		query_x, query_y, query_z, input ready);
	modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
		query_x, query_y, query_z, output ready);
endinterface

interface plf_out_if #(parameter int W = 32) ();
	logic valid;
	logic ready;
	logic signed [W-1:0] line_param;
	logic signed [W-1:0] distance;
	logic degenerate;

	modport source (output valid, line_param, distance, degenerate, input ready);
	modport sink (input valid, line_param, distance, degenerate, output ready);
endinterface

// ----- hdl/plf_front.sv -----
// front end: takes query transactions, forms dot product and squared length
module plf_front import plf_pkg::*; #(
	parameter int W = 32
) (
	input  logic clk,
	input  logic arst_n,
	plf_in_if.sink query,
	input  plf_qstat_t qstat,
	output logic push,
	output logic [(2*W+3)+(2*W)+3*(W+1)+3*W-1:0] entry
);
	localparam int C_W = W + 1;
	localparam int P_W = 2*W + 1;
	localparam int D2_W = 2*W;
	localparam int DOT_W = 2*W + 3;
	localparam int LEN_W = 2*W;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [W-1:0] s_in [3];
	logic signed [W-1:0] q_in [3];
	logic signed [W-1:0] d_in [3];
	logic signed [C_W-1:0] c_s1 [3];
	logic signed [W-1:0] d_s1 [3];
	logic signed [P_W-1:0] pcd_s2 [3];
	logic signed [D2_W-1:0] pdd_s2 [3];
	logic signed [C_W-1:0] c_s2 [3];
	logic signed [W-1:0] d_s2 [3];
	logic signed [DOT_W-1:0] dot_s3;
	logic [LEN_W-1:0] len2_s3;
	logic signed [C_W-1:0] c_s3 [3];
	logic signed [W-1:0] d_s3 [3];

	assign s_in[0] = query.start_x;
	assign s_in[1] = query.start_y;
	assign s_in[2] = query.start_z;
	assign d_in[0] = query.dir_x;
	assign d_in[1] = query.dir_y;
	assign d_in[2] = query.dir_z;
	assign q_in[0] = query.query_x;
	assign q_in[1] = query.query_y;
	assign q_in[2] = query.query_z;

	// the whole front holds only when its last stage cannot enter the queue
	assign en = !(v_s3 && qstat.full);
	assign query.ready = en;
	assign push = v_s3 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= C_W'(q_in[i]) - C_W'(s_in[i]);
				d_s1[i] <= d_in[i];
				pcd_s2[i] <= P_W'(c_s1[i]) * P_W'(d_s1[i]);
				pdd_s2[i] <= D2_W'(d_s1[i]) * D2_W'(d_s1[i]);
				c_s2[i] <= c_s1[i];
				d_s2[i] <= d_s1[i];
				c_s3[i] <= c_s2[i];
				d_s3[i] <= d_s2[i];
			end
			dot_s3 <= DOT_W'(pcd_s2[0]) + DOT_W'(pcd_s2[1]) + DOT_W'(pcd_s2[2]);
			len2_s3 <= LEN_W'($unsigned(pdd_s2[0])) + LEN_W'($unsigned(pdd_s2[1]))
				+ LEN_W'($unsigned(pdd_s2[2]));
		end
	end

	assign entry = {dot_s3, len2_s3, c_s3[0], c_s3[1], c_s3[2], d_s3[0], d_s3[1], d_s3[2]};

endmodule

// ----- hdl/plf_queue.sv -----
// short queue between front and back ends
module plf_queue import plf_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] pop_data,
	output plf_qstat_t stat
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ----- hdl/plf_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module plf_div #(
	parameter int NUM_W = 82,
	parameter int DEN_W = 64,
	parameter int Q_W = 32,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SIDE_W-1:0] side,
	output logic out_valid,
	output logic [Q_W-1:0] quo,
	output logic [DEN_W-1:0] rem,
	output logic [DEN_W-1:0] out_den,
	output logic [SIDE_W-1:0] out_side
);
	logic v_s [Q_W+1];
	logic [DEN_W-1:0] rem_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0] nlo_s [Q_W+1];
	logic [Q_W-1:0] quo_s [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];
	logic [NUM_W-1:0] num_hi;

	// upper part of the dividend is below the divisor unless the quotient overflows
	assign num_hi = num >> Q_W;
	assign v_s[0] = in_valid;
	assign rem_s[0] = num_hi[DEN_W-1:0];
	assign den_s[0] = den;
	assign nlo_s[0] = num[Q_W-1:0];
	assign quo_s[0] = '0;
	assign side_s[0] = side;

	for (genvar j = 1; j <= Q_W; j++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic ge;

		assign trial = {rem_s[j-1], nlo_s[j-1][Q_W-j]};
		assign diff = trial - {1'b0, den_s[j-1]};
		assign ge = (trial >= {1'b0, den_s[j-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[j] <= {quo_s[j-1][Q_W-2:0], ge};
				den_s[j] <= den_s[j-1];
				nlo_s[j] <= nlo_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign quo = quo_s[Q_W];
	assign rem = rem_s[Q_W];
	assign out_den = den_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

// ----- hdl/plf_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module plf_sqrt #(
	parameter int ROOT_W = 32,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*ROOT_W-1:0] rad,
	input  logic [SIDE_W-1:0] side,
	output logic out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] out_side
);
	logic v_s [ROOT_W+1];
	logic [ROOT_W+1:0] rem_s [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [2*ROOT_W-1:0] rad_s [ROOT_W+1];
	logic [SIDE_W-1:0] side_s [ROOT_W+1];

	assign v_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;
	assign side_s[0] = side;

	for (genvar j = 1; j <= ROOT_W; j++) begin : g_step
		logic [ROOT_W+1:0] trial;
		logic [ROOT_W+1:0] test;
		logic ge;

		// bring down the next pair of radicand bits
		assign trial = {rem_s[j-1][ROOT_W-1:0], rad_s[j-1][2*(ROOT_W-j) +: 2]};
		assign test = {root_s[j-1], 2'b01};
		assign ge = (trial >= test);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? (trial - test) : trial;
				root_s[j] <= {root_s[j-1][ROOT_W-2:0], ge};
				rad_s[j] <= rad_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

// ----- hdl/plf_back.sv -----
// back end: parameter division, closest point offset, square root, result register
module plf_back import plf_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  plf_qstat_t qstat,
	input  logic [(2*W+3)+(2*W)+3*(W+1)+3*W-1:0] entry,
	output logic pop,
	plf_out_if.source result
);
	localparam int C_W = W + 1;
	localparam int DOT_W = 2*W + 3;
	localparam int LEN_W = 2*W;
	localparam int MAG_W = 2*W + 2;
	localparam int NUM_W = MAG_W + F;
	localparam int CMP_W = (NUM_W > 3*W) ? NUM_W : 3*W;
	localparam int DSIDE_W = 3 + 3*C_W + 3 + 3*W;
	localparam int RS_W = 2*W + 1;
	localparam int PR_W = RS_W - F;
	localparam int FW = 2*W + 2;
	localparam int SQ_W = 2*W - 2;
	localparam int SSIDE_W = W + 2;
	localparam logic [W-1:0] HALF = W'(1) << (W-1);
	localparam logic [W-1:0] HALF_M1 = HALF - W'(1);
	localparam logic [W-1:0] NEG_ONE = W'(0) - (W'(1) << F);

	logic en;

	// unpacked queue entry
	logic signed [DOT_W-1:0] e_dot, dot_abs;
	logic [LEN_W-1:0] e_len2;
	logic signed [C_W-1:0] e_c [3];
	logic signed [W-1:0] e_d [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic tneg_s1, deg_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [LEN_W-1:0] len2_s1, len2_s2;
	logic signed [C_W-1:0] c_s1 [3];
	logic [2:0] dneg_s1;
	logic [W-1:0] dmag_s1 [3];

	logic [NUM_W-1:0] num_s2;
	logic [DSIDE_W-1:0] dside_s2;

	logic div_valid;
	logic [W-1:0] div_quo;
	logic [LEN_W-1:0] div_rem, div_den;
	logic [DSIDE_W-1:0] div_side;

	logic [W:0] qr_s3;
	logic [DSIDE_W-1:0] dside_s3;
	logic tneg3, ovf3;
	logic [W-1:0] lim3;

	logic [W-1:0] tmag_s4;
	logic tneg_s4, deg_s4;
	logic signed [C_W-1:0] c_s4 [3];
	logic [2:0] dneg_s4;
	logic [W-1:0] dmag_s4 [3];

	logic [2*W-1:0] p_s5 [3];
	logic [W-1:0] tpar_s5, tpar_s6, tpar_s7, tpar_s8, tpar_s9, tpar_s10;
	logic deg_s5, deg_s6, deg_s7, deg_s8, deg_s9, deg_s10;
	logic signed [C_W-1:0] c_s5 [3];
	logic signed [C_W-1:0] c_s6 [3];
	logic [2:0] neg_s5, neg_s6;

	logic [RS_W-1:0] rsum [3];
	logic [PR_W-1:0] pr_s6 [3];
	logic signed [FW-1:0] f_s7 [3];
	logic signed [FW-1:0] fabs [3];
	logic [2:0] big;
	logic [W-2:0] a_s8 [3];
	logic sat_s8, sat_s9, sat_s10;
	logic [SQ_W-1:0] sq_s9 [3];
	logic [2*W-1:0] sum_s10;

	logic sq_valid;
	logic [W-1:0] sq_root, dist_sat;
	logic [SSIDE_W-1:0] sq_side;

	logic out_valid_q, degen_q;
	logic [W-1:0] line_param_q, distance_q;

	assign en = !out_valid_q || result.ready;
	assign pop = en && !qstat.empty;

	assign e_dot = entry[3*W+3*C_W+LEN_W +: DOT_W];
	assign e_len2 = entry[3*W+3*C_W +: LEN_W];
	for (genvar i = 0; i < 3; i++) begin : g_unpack
		assign e_c[i] = entry[3*W + (2-i)*C_W +: C_W];
		assign e_d[i] = entry[(2-i)*W +: W];
	end
	assign dot_abs = e_dot[DOT_W-1] ? -e_dot : e_dot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= div_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			out_valid_q <= sq_valid;
		end
	end

	// magnitude of the dot product, shifted into the dividend; overflow check
	always_ff @(posedge clk) begin
		if (en) begin
			tneg_s1 <= e_dot[DOT_W-1];
			mag_s1 <= dot_abs[MAG_W-1:0];
			len2_s1 <= e_len2;
			deg_s1 <= (e_len2 == '0);
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= e_c[i];
				dneg_s1[i] <= e_d[i][W-1];
				dmag_s1[i] <= e_d[i][W-1] ? (W'(0) - e_d[i]) : e_d[i];
			end
			num_s2 <= {mag_s1, {F{1'b0}}};
			len2_s2 <= len2_s1;
			dside_s2 <= {tneg_s1,
				CMP_W'({mag_s1, {F{1'b0}}}) >= CMP_W'({len2_s1, {W{1'b0}}}),
				deg_s1, c_s1[0], c_s1[1], c_s1[2], dneg_s1,
				dmag_s1[0], dmag_s1[1], dmag_s1[2]};
		end
	end

	plf_div #(
		.NUM_W(NUM_W),
		.DEN_W(LEN_W),
		.Q_W(W),
		.SIDE_W(DSIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.num(num_s2),
		.den(len2_s2),
		.side(dside_s2),
		.out_valid(div_valid),
		.quo(div_quo),
		.rem(div_rem),
		.out_den(div_den),
		.out_side(div_side)
	);

	assign tneg3 = dside_s3[DSIDE_W-1];
	assign ovf3 = dside_s3[DSIDE_W-2];
	assign lim3 = tneg3 ? HALF : HALF_M1;

	// round half away from zero, then saturate to the signed range
	always_ff @(posedge clk) begin
		if (en) begin
			qr_s3 <= (W+1)'(div_quo) + (W+1)'({div_rem, 1'b0} >= {1'b0, div_den});
			dside_s3 <= div_side;
			tmag_s4 <= (ovf3 || (qr_s3 > (W+1)'(lim3))) ? lim3 : qr_s3[W-1:0];
			tneg_s4 <= tneg3;
			deg_s4 <= dside_s3[DSIDE_W-3];
			dneg_s4 <= dside_s3[3*W +: 3];
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= dside_s3[3*W + 3 + (2-i)*C_W +: C_W];
				dmag_s4[i] <= dside_s3[(2-i)*W +: W];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_off
		assign rsum[i] = RS_W'(p_s5[i]) + (RS_W'(1) << (F-1));
		assign fabs[i] = f_s7[i][FW-1] ? -f_s7[i] : f_s7[i];
		assign big[i] = |fabs[i][FW-1:W-1];
	end

	// closest point offset per axis, then squared and summed
	always_ff @(posedge clk) begin
		if (en) begin
			tpar_s5 <= tneg_s4 ? (W'(0) - tmag_s4) : tmag_s4;
			deg_s5 <= deg_s4;
			neg_s5 <= dneg_s4 ^ {3{tneg_s4}};
			tpar_s6 <= tpar_s5;
			deg_s6 <= deg_s5;
			neg_s6 <= neg_s5;
			tpar_s7 <= tpar_s6;
			deg_s7 <= deg_s6;
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= (2*W)'(tmag_s4) * (2*W)'(dmag_s4[i]);
				c_s5[i] <= c_s4[i];
				pr_s6[i] <= rsum[i][RS_W-1:F];
				c_s6[i] <= c_s5[i];
				f_s7[i] <= neg_s6[i] ? ($signed(FW'(pr_s6[i])) + FW'(c_s6[i]))
					: ($signed(FW'(pr_s6[i])) - FW'(c_s6[i]));
				a_s8[i] <= fabs[i][W-2:0];
				sq_s9[i] <= SQ_W'(a_s8[i]) * SQ_W'(a_s8[i]);
			end
			sat_s8 <= |big;
			tpar_s8 <= tpar_s7;
			deg_s8 <= deg_s7;
			sat_s9 <= sat_s8;
			tpar_s9 <= tpar_s8;
			deg_s9 <= deg_s8;
			sum_s10 <= (2*W)'(sq_s9[0]) + (2*W)'(sq_s9[1]) + (2*W)'(sq_s9[2]);
			sat_s10 <= sat_s9;
			tpar_s10 <= tpar_s9;
			deg_s10 <= deg_s9;
		end
	end

	plf_sqrt #(
		.ROOT_W(W),
		.SIDE_W(SSIDE_W)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s10),
		.rad(sum_s10),
		.side({sat_s10, deg_s10, tpar_s10}),
		.out_valid(sq_valid),
		.root(sq_root),
		.out_side(sq_side)
	);

	assign dist_sat = (sq_side[W+1] || sq_root[W-1]) ? HALF_M1 : sq_root;

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= sq_side[W];
			line_param_q <= sq_side[W] ? '0 : sq_side[W-1:0];
			distance_q <= sq_side[W] ? NEG_ONE : dist_sat;
		end
	end

	assign result.valid = out_valid_q;
	assign result.line_param = line_param_q;
	assign result.distance = distance_q;
	assign result.degenerate = degen_q;

endmodule

// ----- hdl/point_line_distance_top.sv -----
// top level of the point to line distance block
//
//  channel  | dir | handshake      | payload
//  query    | in  | valid / ready  | start_xyz, dir_xyz, query_xyz (signed Q format)
//  result   | out | valid / ready  | line_param, distance, degenerate
//
// one transaction accepted per cycle unless the queue is full, one result per cycle while
// result.ready is high, in order; the divider and square root each take one pipeline
// stage per result bit
// arst_n clears every valid flag and the queue pointers; payload is not reset
// a stalled result holds the back end; the front keeps filling the queue and
// drops query.ready only once the queue is full
module point_line_distance_top import plf_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	plf_in_if.sink query,
	plf_out_if.source result
);
	localparam int ENTRY_W = (2*COORD_WIDTH+3) + (2*COORD_WIDTH) + 3*(COORD_WIDTH+1)
		+ 3*COORD_WIDTH;

	logic push, pop;
	logic [ENTRY_W-1:0] push_data, pop_data;
	plf_qstat_t qstat;

	plf_front #(
		.W(COORD_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.qstat(qstat),
		.push(push),
		.entry(push_data)
	);

	plf_queue #(
		.WIDTH(ENTRY_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.stat(qstat)
	);

	plf_back #(
		.W(COORD_WIDTH),
		.F(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.entry(pop_data),
		.pop(pop),
		.result(result)
	);

endmodule

// ----- hdl/plf_checker.sv -----
// port level checks on the top level, attached by bind
module plf_checker #(
	parameter int W = 32,
	parameter int F = 16
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [W-1:0] line_param,
	input logic [W-1:0] distance,
	input logic degenerate
);
	localparam logic [W-1:0] NEG_ONE = W'(0) - (W'(1) << F);

	// a held result keeps its distance and line_param
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(line_param))
		else $error("result changed while stalled");

	// zero direction gives parameter zero and distance of minus one
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> line_param == '0 && distance == NEG_ONE)
		else $error("degenerate result fields wrong");

	// a real distance is never negative
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> !distance[W-1])
		else $error("negative distance");

	// no result straight out of reset
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid after reset");

endmodule

bind point_line_distance_top plf_checker #(
	.W(COORD_WIDTH),
	.F(FRAC_BITS)
) u_plf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.line_param(result.line_param),
	.distance(result.distance),
	.degenerate(result.degenerate)
);

// ----- tb/point_line_distance_top_test.sv -----
// testbench for the point to line distance block: directed table, then random traffic
`timescale 1ns / 1ps

module point_line_distance_top_test;
	import plf_pkg::*;

	localparam int W = 32;
	localparam int FB = 16;
	localparam int N_RANDOM = 1300;
	localparam int DRAIN_CYCLES = 2 * W + 17 + 100;

	typedef struct {
		logic signed [W-1:0] sx, sy, sz, dx, dy, dz, qx, qy, qz;
	} query_t;

	typedef struct {
		logic signed [W-1:0] line_param;
		logic signed [W-1:0] distance;
		logic degenerate;
	} answer_t;

	typedef struct {
		query_t q;
		bit typed;
		answer_t a;
	} row_t;

	logic clk;
	logic arst_n;
	plf_in_if #(W) q_if ();
	plf_out_if #(W) r_if ();

	point_line_distance_top #(.COORD_WIDTH(W), .FRAC_BITS(FB)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.query(q_if),
		.result(r_if)
	);

	answer_t pending_answers[$];
	answer_t typed_answers[$];
	bit typed_flags[$];
	int err_count = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit cur_typed = 0;
	answer_t cur_typed_ans;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [127:0] isqrt128(input logic [127:0] n);
		logic [127:0] res, one, t;
		res = '0;
		one = 128'd1 << 126;
		while (one > n) one = one >> 2;
		while (one != 0) begin
			t = res + one;
			if (n >= t) begin
				n = n - t;
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic answer_t closest_distance(input query_t q);
		logic signed [127:0] s[3], d[3], c[3], dot, len2, e, p;
		logic [127:0] num, tq, rem, tmag, lim, absd, sum, r, half;
		logic tneg, sat;
		answer_t a;
		s[0] = q.sx; s[1] = q.sy; s[2] = q.sz;
		d[0] = q.dx; d[1] = q.dy; d[2] = q.dz;
		c[0] = q.qx; c[1] = q.qy; c[2] = q.qz;
		dot = 0;
		len2 = 0;
		sum = 0;
		sat = 0;
		half = 128'd1 << (W - 1);
		for (int i = 0; i < 3; i++) begin
			c[i] = c[i] - s[i];
			dot = dot + c[i] * d[i];
			len2 = len2 + d[i] * d[i];
		end
		if (len2 == 0) begin
			a.line_param = '0;
			a.distance = -(W'(1) << FB);
			a.degenerate = 1'b1;
			return a;
		end
		tneg = dot[127];
		num = (tneg ? -dot : dot) << FB;
		tq = num / len2;
		rem = num % len2;
		if ((rem << 1) >= len2) tq = tq + 1;
		lim = tneg ? half : half - 1;
		tmag = (tq > lim) ? lim : tq;
		for (int i = 0; i < 3; i++) begin
			absd = d[i][127] ? -d[i] : d[i];
			p = (tmag * absd + (128'd1 << (FB - 1))) >> FB;
			if (tneg != d[i][127]) p = -p;
			e = p - c[i];
			if (e[127]) e = -e;
			if (e >= half) sat = 1;
			else sum = sum + e * e;
		end
		if (sat) begin
			a.distance = W'(half - 1);
		end else begin
			r = isqrt128(sum);
			a.distance = (r > half - 1) ? W'(half - 1) : W'(r);
		end
		a.line_param = tneg ? W'(-tmag) : W'(tmag);
		a.degenerate = 1'b0;
		return a;
	endfunction

	// predict on every accepted query transaction
	always @(posedge clk) begin
		query_t q;
		if (arst_n && q_if.valid && q_if.ready) begin
			q.sx = q_if.start_x; q.sy = q_if.start_y; q.sz = q_if.start_z;
			q.dx = q_if.dir_x; q.dy = q_if.dir_y; q.dz = q_if.dir_z;
			q.qx = q_if.query_x; q.qy = q_if.query_y; q.qz = q_if.query_z;
			pending_answers.push_back(closest_distance(q));
			typed_flags.push_back(cur_typed);
			typed_answers.push_back(cur_typed_ans);
		end
	end

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin
		answer_t exp_a, typ_a;
		bit typ;
		if (arst_n && r_if.valid && r_if.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("result with no query outstanding");
			end else begin
				exp_a = pending_answers.pop_front();
				typ = typed_flags.pop_front();
				typ_a = typed_answers.pop_front();
				if (typ) exp_a = typ_a;
				if (r_if.line_param !== exp_a.line_param)
					report_mismatch($sformatf("line_param got %h want %h",
						r_if.line_param, exp_a.line_param));
				if (r_if.distance !== exp_a.distance)
					report_mismatch($sformatf("distance got %h want %h",
						r_if.distance, exp_a.distance));
				if (r_if.degenerate !== exp_a.degenerate)
					report_mismatch($sformatf("degenerate got %b want %b",
						r_if.degenerate, exp_a.degenerate));
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		r_if.ready = ($urandom_range(99) >= rcv_stall_pct);
	end

	task automatic send_query(input query_t q);
		while ($urandom_range(99) < snd_idle_pct) begin
			q_if.valid = 1'b0;
			@(negedge clk);
		end
		q_if.valid = 1'b1;
		q_if.start_x = q.sx; q_if.start_y = q.sy; q_if.start_z = q.sz;
		q_if.dir_x = q.dx; q_if.dir_y = q.dy; q_if.dir_z = q.dz;
		q_if.query_x = q.qx; q_if.query_y = q.qy; q_if.query_z = q.qz;
		do @(posedge clk); while (!q_if.ready);
		@(negedge clk);
		q_if.valid = 1'b0;
	endtask

	function automatic logic [W-1:0] rand_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return W'($signed($urandom_range(2 * 1048576)) - 1048576);
			2: return W'($signed($urandom_range(512)) - 256);
			default: begin
				case ($urandom_range(3))
					0: return {1'b1, {(W-1){1'b0}}};
					1: return {1'b0, {(W-1){1'b1}}};
					2: return '0;
					default: return {W{1'b1}};
				endcase
			end
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		int kind;
		kind = $urandom_range(9);
		// mix: full range, moderate, tiny, extremes
		kind = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 8) ? 2 : 3;
		q.sx = rand_coord(kind); q.sy = rand_coord(kind); q.sz = rand_coord(kind);
		q.dx = rand_coord(kind); q.dy = rand_coord(kind); q.dz = rand_coord(kind);
		q.qx = rand_coord(kind); q.qy = rand_coord(kind); q.qz = rand_coord(kind);
		if ($urandom_range(9) == 0) begin
			q.dx = '0; q.dy = '0; q.dz = '0;
		end else if ($urandom_range(9) == 0) begin
			// direction along one axis only
			q.dy = '0; q.dz = '0;
		end
		return q;
	endfunction

	function automatic row_t mk_row(input logic [W-1:0] v[9], input bit typed,
			input logic [W-1:0] lp, input logic [W-1:0] dst, input logic dg);
		row_t r;
		r.q.sx = v[0]; r.q.sy = v[1]; r.q.sz = v[2];
		r.q.dx = v[3]; r.q.dy = v[4]; r.q.dz = v[5];
		r.q.qx = v[6]; r.q.qy = v[7]; r.q.qz = v[8];
		r.typed = typed;
		r.a.line_param = lp;
		r.a.distance = dst;
		r.a.degenerate = dg;
		return r;
	endfunction

	localparam logic [W-1:0] MX = 32'h7fffffff;
	localparam logic [W-1:0] MN = 32'h80000000;
	localparam logic [W-1:0] ONE = 32'h00010000;
	localparam logic [W-1:0] NEG1 = 32'hffff0000;

	row_t stim_table[$];

	initial begin
		q_if.valid = 1'b0;
		q_if.start_x = '0; q_if.start_y = '0; q_if.start_z = '0;
		q_if.dir_x = '0; q_if.dir_y = '0; q_if.dir_z = '0;
		q_if.query_x = '0; q_if.query_y = '0; q_if.query_z = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero direction
		stim_table.push_back(mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, NEG1, 1));
		stim_table.push_back(mk_row('{MX, MN, MX, 0, 0, 0, MN, MX, MN}, 1, 0, NEG1, 1));
		// query on the origin, unit direction
		stim_table.push_back(mk_row('{0, 0, 0, ONE, 0, 0, 0, 0, 0}, 1, 0, 0, 0));
		// query one unit along the line
		stim_table.push_back(mk_row('{0, 0, 0, ONE, 0, 0, ONE, 0, 0}, 1, ONE, 0, 0));
		// query one unit off the line
		stim_table.push_back(mk_row('{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, 0, ONE, 0));
		// behind the origin
		stim_table.push_back(mk_row('{0, 0, 0, ONE, 0, 0, NEG1, 0, 0}, 1, NEG1, 0, 0));
		// parameter overflow: tiny direction, far query
		stim_table.push_back(mk_row('{0, 0, 0, 1, 0, 0, MX, 0, 0}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{0, 0, 0, 1, 0, 0, MN, 0, 0}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{MX, 0, 0, 1, 1, 1, MN, MX, MN}, 0, 0, 0, 0));
		// distance overflow
		stim_table.push_back(mk_row('{MN, MN, MN, ONE, 0, 0, MN, MX, MX}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{MN, MN, MN, 0, 0, ONE, MX, MX, MN}, 0, 0, 0, 0));
		// field extremes, then small and mixed values
		stim_table.push_back(mk_row('{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{MN, MN, MN, MN, MN, MN, MN, MN, MN}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{MN, MX, MN, MX, MN, MX, MN, MX, MN}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{MX, MN, MX, MN, MX, MN, MX, MN, MX}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{0, 0, 0, MN, 0, 0, MX, MX, MX}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{1, 2, 3, -1, -1, -1, -5, 7, 9}, 0, 0, 0, 0));
		stim_table.push_back(mk_row('{ONE, NEG1, ONE, 3, -7, 11, NEG1, ONE, 0}, 0, 0, 0, 0));

		foreach (stim_table[i]) begin
			cur_typed = stim_table[i].typed;
			cur_typed_ans = stim_table[i].a;
			send_query(stim_table[i].q);
		end
		cur_typed = 0;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin snd_idle_pct = 65; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 65; end
				default: begin snd_idle_pct = 38; rcv_stall_pct = 38; end
			endcase
			for (int k = 0; k < N_RANDOM / 4; k++) send_query(random_query());
		end
		snd_idle_pct = 0;
		rcv_stall_pct = 0;

		while (pending_answers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/plf_pkg.sv
hdl/plf_if.sv
hdl/plf_front.sv
hdl/plf_queue.sv
hdl/plf_div.sv
hdl/plf_sqrt.sv
hdl/plf_back.sv
hdl/point_line_distance_top.sv
hdl/plf_checker.sv
tb/point_line_distance_top_test.sv
